// ----- rtl/rvcore_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the rv64i subset core
// no dependencies

package rvcore_pkg;

  localparam int DataBytesDefault = 1024;
  localparam int RegCount         = 32;
  localparam int RegIdxW          = 5;
  localparam int XLen             = 64;

  localparam logic [6:0] OPC_R    = 7'b0110011;
  localparam logic [6:0] OPC_I    = 7'b0010011;
  localparam logic [6:0] OPC_LD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR = 7'b1100111;
  localparam logic [6:0] OPC_SD   = 7'b0100011;
  localparam logic [6:0] OPC_BR   = 7'b1100011;
  localparam logic [6:0] OPC_JAL  = 7'b1101111;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_DW   = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_SUB  = 7'b0100000;

  localparam logic ADDR_LAST_INSTR = 1'b0;

  typedef enum logic [2:0] {
    OP_NOP, OP_ALU, OP_LD, OP_SD, OP_BR, OP_JAL, OP_JALR
  } op_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_XOR, ALU_SRL, ALU_OR, ALU_AND
  } alu_t;

  typedef enum logic [1:0] {
    BR_EQ, BR_NE, BR_LT, BR_GE
  } br_t;

  typedef struct packed {
    op_t                op;
    alu_t               alu;
    br_t                br;
    logic               use_imm;
    logic [RegIdxW-1:0] rd;
    logic [RegIdxW-1:0] rs1;
    logic [RegIdxW-1:0] rs2;
    logic [31:0]        imm;
  } dec_t;

endpackage

// ----- rtl/riscv_subset_single_cycle_core_unit.sv -----
`timescale 1ns / 1ps
// rv64i subset core: one instruction per cycle sustained while out_ready holds; each
// accepted instruction passes through queue entry, execute and result stage
// the execute stage resolves pc and operands combinationally
// reset: pc, registers and config cleared; the data memory is then zeroed one
// row per cycle, DATA_BYTES/8 rows in all, during which no instruction is accepted
// depends on rvcore_pkg, rvcore_front, rvcore_back, rvcore_ram

module riscv_subset_single_cycle_core_unit #(
  parameter int DATA_BYTES = rvcore_pkg::DataBytesDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [31:0]                        instr_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [31:0]                        next_pc,
  output logic                               wb_enable,
  output logic [rvcore_pkg::RegIdxW-1:0]     wb_index,
  output logic signed [rvcore_pkg::XLen-1:0] wb_value,
  output logic                               store_done,
  output logic                               halted
);

  logic [31:0]      last_instr_addr;
  logic             clearing;
  logic             q_valid;
  logic             q_pop;
  rvcore_pkg::dec_t q_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rvcore_pkg::ADDR_LAST_INSTR) ? last_instr_addr : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_instr_addr <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == rvcore_pkg::ADDR_LAST_INSTR) begin
      last_instr_addr <= pwdata;
    end
  end

  rvcore_front u_front (
    .clk(clk), .rst(rst), .enable(!clearing),
    .in_valid(in_valid), .in_ready(in_ready), .instr_word(instr_word),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  rvcore_back #(.DATA_BYTES(DATA_BYTES)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .last_instr_addr(last_instr_addr), .clearing(clearing),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pc(next_pc), .wb_enable(wb_enable), .wb_index(wb_index),
    .wb_value(wb_value), .store_done(store_done), .halted(halted)
  );

endmodule

// ----- rtl/rvcore_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module rvcore_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rvcore_front.sv -----
`timescale 1ns / 1ps
// front end: accepts instruction words, decodes them and queues the result
// depends on rvcore_pkg

module rvcore_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               enable,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        instr_word,
  output logic               q_valid,
  output rvcore_pkg::dec_t   q_item,
  input  logic               q_pop
);

  function automatic rvcore_pkg::dec_t decode(input logic [31:0] w);
    rvcore_pkg::dec_t d;
    logic [6:0] f7;
    logic [2:0] f3;
    logic       alu_ok;
    f7 = w[31:25];
    f3 = w[14:12];
    d.op      = rvcore_pkg::OP_NOP;
    d.br      = rvcore_pkg::BR_EQ;
    d.use_imm = 1'b0;
    d.rd      = w[11:7];
    d.rs1     = w[19:15];
    d.rs2     = w[24:20];
    d.imm     = {{20{w[31]}}, w[31:20]};
    alu_ok    = 1'b1;
    d.alu     = rvcore_pkg::ALU_ADD;
    unique case (f3)
      rvcore_pkg::F3_ADD: d.alu = rvcore_pkg::ALU_ADD;
      rvcore_pkg::F3_SLL: d.alu = rvcore_pkg::ALU_SLL;
      rvcore_pkg::F3_SLT: d.alu = rvcore_pkg::ALU_SLT;
      rvcore_pkg::F3_XOR: d.alu = rvcore_pkg::ALU_XOR;
      rvcore_pkg::F3_SRL: d.alu = rvcore_pkg::ALU_SRL;
      rvcore_pkg::F3_OR:  d.alu = rvcore_pkg::ALU_OR;
      rvcore_pkg::F3_AND: d.alu = rvcore_pkg::ALU_AND;
      default:            alu_ok = 1'b0;
    endcase
    unique case (w[6:0])
      rvcore_pkg::OPC_R: begin
        if (alu_ok && (f7 == rvcore_pkg::F7_BASE ||
                       (f7 == rvcore_pkg::F7_SUB && f3 == rvcore_pkg::F3_ADD))) begin
          d.op = rvcore_pkg::OP_ALU;
          if (f7 == rvcore_pkg::F7_SUB) begin
            d.alu = rvcore_pkg::ALU_SUB;
          end
        end
      end
      rvcore_pkg::OPC_I: begin
        d.use_imm = 1'b1;
        if (alu_ok && !((f3 == rvcore_pkg::F3_SLL || f3 == rvcore_pkg::F3_SRL) &&
                        w[31:26] != 6'd0)) begin
          d.op = rvcore_pkg::OP_ALU;
        end
      end
      rvcore_pkg::OPC_LD: begin
        if (f3 == rvcore_pkg::F3_DW) begin
          d.op = rvcore_pkg::OP_LD;
        end
      end
      rvcore_pkg::OPC_SD: begin
        d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        if (f3 == rvcore_pkg::F3_DW) begin
          d.op = rvcore_pkg::OP_SD;
        end
      end
      rvcore_pkg::OPC_BR: begin
        d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        d.op  = rvcore_pkg::OP_BR;
        case (f3)
          rvcore_pkg::F3_BEQ: d.br = rvcore_pkg::BR_EQ;
          rvcore_pkg::F3_BNE: d.br = rvcore_pkg::BR_NE;
          rvcore_pkg::F3_BLT: d.br = rvcore_pkg::BR_LT;
          rvcore_pkg::F3_BGE: d.br = rvcore_pkg::BR_GE;
          default:            d.op = rvcore_pkg::OP_NOP;
        endcase
      end
      rvcore_pkg::OPC_JAL: begin
        d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        d.op  = rvcore_pkg::OP_JAL;
      end
      rvcore_pkg::OPC_JALR: begin
        if (f3 == rvcore_pkg::F3_ADD) begin
          d.op = rvcore_pkg::OP_JALR;
        end
      end
      default: d.op = rvcore_pkg::OP_NOP;
    endcase
    return d;
  endfunction

  // two-entry queue towards the back end
  rvcore_pkg::dec_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = enable && (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= decode(instr_word);
    end
  end

endmodule

// ----- rtl/rvcore_back.sv -----
`timescale 1ns / 1ps
// back end: register file, execute stage, data memory and result stage
// depends on rvcore_pkg and rvcore_ram

module rvcore_back #(
  parameter int DATA_BYTES = rvcore_pkg::DataBytesDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  rvcore_pkg::dec_t                    q_item,
  output logic                                q_pop,
  input  logic [31:0]                         last_instr_addr,
  output logic                                clearing,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [31:0]                         next_pc,
  output logic                                wb_enable,
  output logic [rvcore_pkg::RegIdxW-1:0]      wb_index,
  output logic signed [rvcore_pkg::XLen-1:0]  wb_value,
  output logic                                store_done,
  output logic                                halted
);

  localparam int AW   = $clog2(DATA_BYTES);
  localparam int ROWS = DATA_BYTES / 8;
  localparam int RW   = AW - 3;
  localparam int XL   = rvcore_pkg::XLen;
  localparam int IW   = rvcore_pkg::RegIdxW;

  // execute stage
  logic             x_valid;
  rvcore_pkg::dec_t x_item;
  logic             x_vld1;
  logic             x_vld2;
  logic [31:0]      pc;

  // write that landed on the same edge as the register file read
  logic          lw_en;
  logic [IW-1:0] lw_idx;
  logic [XL-1:0] lw_val;

  // result stage
  logic          w_valid;
  logic [31:0]   w_npc;
  logic          w_wb_en;
  logic [IW-1:0] w_idx;
  logic [XL-1:0] w_val;
  logic          w_load;
  logic [2:0]    w_lo;
  logic          w_st;
  logic          w_halt;

  logic [rvcore_pkg::RegCount-1:0] vld;
  logic [XL-1:0] rf_a;
  logic [XL-1:0] rf_b;
  logic [XL-1:0] w_res;
  logic [XL-1:0] ld_data;
  logic          w_fire;
  logic          x_adv;
  logic          rf_we;

  logic [RW-1:0] clr_row;

  logic [XL-1:0] op_a;
  logic [XL-1:0] op_b;
  logic [XL-1:0] op2;
  logic [XL-1:0] imm64;
  logic [XL-1:0] alu_res;
  logic [XL-1:0] addsum;
  logic [31:0]   pc4;
  logic [31:0]   npc;
  logic          take;
  logic          x_wr;
  logic [XL-1:0] x_val;
  logic [2:0]    lo;
  logic [RW-1:0] row0;
  logic [RW-1:0] row1;
  logic          x_st;
  logic          x_ld;

  logic [RW-1:0] bk_addr  [8];
  logic [7:0]    bk_wdata [8];
  logic [7:0]    bk_rdata [8];
  logic          bk_we;

  assign w_fire    = w_valid && out_ready;
  assign x_adv     = x_valid && (!w_valid || out_ready);
  assign q_pop     = q_valid && !clearing && (!x_valid || x_adv);
  assign out_valid = w_valid;

  // register file: two copies give two read ports
  assign w_res = w_load ? ld_data : w_val;
  assign rf_we = w_fire && w_wb_en;

  rvcore_ram #(.WIDTH(XL), .DEPTH(rvcore_pkg::RegCount)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(w_idx), .wdata(w_res),
    .re(q_pop), .raddr(q_item.rs1), .rdata(rf_a)
  );

  rvcore_ram #(.WIDTH(XL), .DEPTH(rvcore_pkg::RegCount)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(w_idx), .wdata(w_res),
    .re(q_pop), .raddr(q_item.rs2), .rdata(rf_b)
  );

  // operand bypass: result stage first, then the write hidden from the read
  always_comb begin
    if (w_valid && w_wb_en && w_idx == x_item.rs1) begin
      op_a = w_res;
    end else if (lw_en && lw_idx == x_item.rs1) begin
      op_a = lw_val;
    end else begin
      op_a = x_vld1 ? rf_a : '0;
    end
    if (w_valid && w_wb_en && w_idx == x_item.rs2) begin
      op_b = w_res;
    end else if (lw_en && lw_idx == x_item.rs2) begin
      op_b = lw_val;
    end else begin
      op_b = x_vld2 ? rf_b : '0;
    end
  end

  assign imm64  = {{(XL-32){x_item.imm[31]}}, x_item.imm};
  assign op2    = x_item.use_imm ? imm64 : op_b;
  assign addsum = op_a + imm64;
  assign pc4    = pc + 32'd4;

  always_comb begin
    case (x_item.alu)
      rvcore_pkg::ALU_ADD: alu_res = op_a + op2;
      rvcore_pkg::ALU_SUB: alu_res = op_a - op2;
      rvcore_pkg::ALU_SLL: alu_res = op_a << op2[5:0];
      rvcore_pkg::ALU_SLT: alu_res = {{(XL-1){1'b0}}, ($signed(op_a) < $signed(op2))};
      rvcore_pkg::ALU_XOR: alu_res = op_a ^ op2;
      rvcore_pkg::ALU_SRL: alu_res = op_a >> op2[5:0];
      rvcore_pkg::ALU_OR:  alu_res = op_a | op2;
      rvcore_pkg::ALU_AND: alu_res = op_a & op2;
      default:             alu_res = '0;
    endcase
  end

  always_comb begin
    case (x_item.br)
      rvcore_pkg::BR_EQ: take = (op_a == op_b);
      rvcore_pkg::BR_NE: take = (op_a != op_b);
      rvcore_pkg::BR_LT: take = ($signed(op_a) < $signed(op_b));
      rvcore_pkg::BR_GE: take = !($signed(op_a) < $signed(op_b));
      default:           take = 1'b0;
    endcase
  end

  always_comb begin
    npc   = pc4;
    x_wr  = 1'b0;
    x_val = '0;
    unique case (x_item.op)
      rvcore_pkg::OP_ALU: begin
        x_wr  = 1'b1;
        x_val = alu_res;
      end
      rvcore_pkg::OP_LD: x_wr = 1'b1;
      rvcore_pkg::OP_BR: begin
        if (take) begin
          npc = pc + x_item.imm;
        end
      end
      rvcore_pkg::OP_JAL: begin
        x_wr  = 1'b1;
        x_val = {{(XL-32){1'b0}}, pc4};
        npc   = pc + x_item.imm;
      end
      rvcore_pkg::OP_JALR: begin
        x_wr  = 1'b1;
        x_val = {{(XL-32){1'b0}}, pc4};
        npc   = {addsum[31:1], 1'b0};
      end
      default: npc = pc4;
    endcase
  end

  // data memory: eight byte banks, a doubleword may straddle two rows
  assign x_st  = x_adv && x_item.op == rvcore_pkg::OP_SD;
  assign x_ld  = x_adv && x_item.op == rvcore_pkg::OP_LD;
  assign lo    = addsum[2:0];
  assign row0  = addsum[AW-1:3];
  assign row1  = row0 + RW'(1);
  assign bk_we = clearing || x_st;

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [2:0] k;
    assign k = 3'(b) - lo;
    assign bk_addr[b]  = clearing ? clr_row : ((3'(b) < lo) ? row1 : row0);
    assign bk_wdata[b] = clearing ? 8'd0 : op_b[8*k +: 8];

    rvcore_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk(clk), .we(bk_we), .waddr(bk_addr[b]), .wdata(bk_wdata[b]),
      .re(x_ld), .raddr(bk_addr[b]), .rdata(bk_rdata[b])
    );

    assign ld_data[8*b +: 8] = bk_rdata[3'(b) + w_lo];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + RW'(1);
      if (clr_row == RW'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
      w_valid <= 1'b0;
      pc      <= '0;
      vld     <= '0;
      lw_en   <= 1'b0;
    end else begin
      if (rf_we) begin
        vld[w_idx] <= 1'b1;
      end
      if (q_pop) begin
        lw_en <= rf_we;
      end
      if (q_pop) begin
        x_valid <= 1'b1;
      end else if (x_adv) begin
        x_valid <= 1'b0;
      end
      if (x_adv) begin
        w_valid <= 1'b1;
        pc      <= npc;
      end else if (w_fire) begin
        w_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_item <= q_item;
      x_vld1 <= vld[q_item.rs1];
      x_vld2 <= vld[q_item.rs2];
      lw_idx <= w_idx;
      lw_val <= w_res;
    end
    if (x_adv) begin
      w_npc   <= npc;
      w_wb_en <= x_wr && (x_item.rd != '0);
      w_idx   <= x_item.rd;
      w_val   <= x_val;
      w_load  <= (x_item.op == rvcore_pkg::OP_LD);
      w_lo    <= lo;
      w_st    <= (x_item.op == rvcore_pkg::OP_SD);
      w_halt  <= (npc > last_instr_addr);
    end
  end

  assign next_pc    = w_npc;
  assign wb_enable  = w_wb_en;
  assign wb_index   = w_wb_en ? w_idx : '0;
  assign wb_value   = $signed(w_wb_en ? w_res : '0);
  assign store_done = w_st;
  assign halted     = w_halt;

endmodule

// ----- bench/riscv_subset_single_cycle_core_unit_test.sv -----
`timescale 1ns / 1ps
// testbench for the rv64i subset core: drives instructions and register writes,
// predicts every retirement with its own executor model and checks each field
// depends on rvcore_pkg and riscv_subset_single_cycle_core_unit

module riscv_subset_single_cycle_core_unit_test;

  localparam int MemBytes    = 1024;
  localparam int HoldCycles  = 60;

  typedef struct packed {
    logic [31:0] pc;
    logic        wen;
    logic [4:0]  widx;
    logic [63:0] wval;
    logic        st;
    logic        hlt;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instr_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] next_pc;
  logic        wb_enable;
  logic [4:0]  wb_index;
  logic signed [63:0] wb_value;
  logic        store_done, halted;

  riscv_subset_single_cycle_core_unit #(.DATA_BYTES(MemBytes)) uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] model_pc;
  logic [63:0] model_regs [32];
  logic [7:0]  model_mem [MemBytes];
  logic [31:0] model_last;

  retire_t expected_retires[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_active = 1'b0;
  event        hold_go;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [63:0] sx12(input logic [11:0] v);
    return {{52{v[11]}}, v};
  endfunction

  function automatic logic alu_eval(input logic [2:0] f3, input logic sub,
                                    input logic [63:0] a, input logic [63:0] b,
                                    output logic [63:0] r);
    r = '0;
    case (f3)
      rvcore_pkg::F3_ADD: r = sub ? a - b : a + b;
      rvcore_pkg::F3_SLL: r = a << b[5:0];
      rvcore_pkg::F3_SLT: r = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      rvcore_pkg::F3_XOR: r = a ^ b;
      rvcore_pkg::F3_SRL: r = a >> b[5:0];
      rvcore_pkg::F3_OR:  r = a | b;
      rvcore_pkg::F3_AND: r = a & b;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic retire_t execute_instr(input logic [31:0] w);
    retire_t     res;
    logic [6:0]  opc, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [63:0] a, b, val, base, off;
    logic        wr, st, take;
    opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15];
    rs2 = w[24:20]; f7 = w[31:25];
    a = model_regs[rs1]; b = model_regs[rs2];
    val = '0; wr = 1'b0; st = 1'b0; take = 1'b0;
    res.pc = model_pc + 32'd4;
    case (opc)
      rvcore_pkg::OPC_R:
        if (f7 == rvcore_pkg::F7_BASE ||
            (f7 == rvcore_pkg::F7_SUB && f3 == rvcore_pkg::F3_ADD))
          wr = alu_eval(f3, f7 == rvcore_pkg::F7_SUB, a, b, val);
      rvcore_pkg::OPC_I:
        if (!((f3 == rvcore_pkg::F3_SLL || f3 == rvcore_pkg::F3_SRL) &&
              w[31:26] != 6'd0))
          wr = alu_eval(f3, 1'b0, a, sx12(w[31:20]), val);
      rvcore_pkg::OPC_LD:
        if (f3 == rvcore_pkg::F3_DW) begin
          base = a + sx12(w[31:20]);
          for (int k = 0; k < 8; k++)
            val[8*k +: 8] = model_mem[(base + k) % MemBytes];
          wr = 1'b1;
        end
      rvcore_pkg::OPC_SD:
        if (f3 == rvcore_pkg::F3_DW) begin
          base = a + sx12({f7, rd});
          for (int k = 0; k < 8; k++)
            model_mem[(base + k) % MemBytes] = b[8*k +: 8];
          st = 1'b1;
        end
      rvcore_pkg::OPC_BR: begin
        off = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          rvcore_pkg::F3_BEQ: take = (a == b);
          rvcore_pkg::F3_BNE: take = (a != b);
          rvcore_pkg::F3_BLT: take = ($signed(a) < $signed(b));
          rvcore_pkg::F3_BGE: take = !($signed(a) < $signed(b));
          default: take = 1'b0;
        endcase
        if (take) res.pc = model_pc + off[31:0];
      end
      rvcore_pkg::OPC_JAL: begin
        off = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        val = {32'd0, model_pc + 32'd4};
        wr = 1'b1;
        res.pc = model_pc + off[31:0];
      end
      rvcore_pkg::OPC_JALR:
        if (f3 == rvcore_pkg::F3_ADD) begin
          base = (a + sx12(w[31:20])) & ~64'd1;
          val = {32'd0, model_pc + 32'd4};
          wr = 1'b1;
          res.pc = base[31:0];
        end
      default: ;
    endcase
    if (wr && rd != 5'd0) model_regs[rd] = val;
    else begin
      wr = 1'b0; val = '0;
    end
    model_pc = res.pc;
    res.wen = wr; res.widx = wr ? rd : 5'd0; res.wval = val;
    res.st = st; res.hlt = res.pc > model_last;
    return res;
  endfunction

  task automatic send_instr(input logic [31:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    instr_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_retires.push_back(execute_instr(w));
  endtask

  always @(posedge clk) begin
    retire_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_retires.size() == 0) begin
        report_mismatch("unexpected transaction", {32'd0, next_pc}, 64'd0);
      end else begin
        want = expected_retires.pop_front();
        if (next_pc !== want.pc)
          report_mismatch("next_pc", {32'd0, next_pc}, {32'd0, want.pc});
        if (wb_enable !== want.wen)
          report_mismatch("wb_enable", 64'(wb_enable), 64'(want.wen));
        if (wb_index !== want.widx)
          report_mismatch("wb_index", 64'(wb_index), 64'(want.widx));
        if (wb_value !== want.wval) report_mismatch("wb_value", wb_value, want.wval);
        if (store_done !== want.st)
          report_mismatch("store_done", 64'(store_done), 64'(want.st));
        if (halted !== want.hlt)
          report_mismatch("halted", 64'(halted), 64'(want.hlt));
      end
    end
  end

  // long hold-off of the receiver, counted in its own process
  initial forever begin
    @(hold_go);
    hold_active <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_active <= 1'b0;
  end

  // receiver: random stalls, held off while a hold is active
  always @(posedge clk) begin
    if (hold_active)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_retires.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_last_addr(input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {rvcore_pkg::ADDR_LAST_INSTR, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    model_last = v;
  endtask

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, rvcore_pkg::OPC_R};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [4:0] rs1, input logic [4:0] rs2,
                                        input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, rvcore_pkg::F3_DW, imm[4:0], rvcore_pkg::OPC_SD};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [12:0] off);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], rvcore_pkg::OPC_BR};
  endfunction

  // loads and stores take their base from x0..x4 only, so that loads can see stores
  function automatic logic [31:0] random_instr;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [11:0] imm;
    rd = 5'($urandom); rs1 = 5'($urandom_range(4)); rs2 = 5'($urandom);
    f3 = 3'($urandom); imm = 12'($urandom);
    case ($urandom_range(15))
      0, 1, 2: return enc_r(($urandom_range(3) == 0) ? rvcore_pkg::F7_SUB :
                            rvcore_pkg::F7_BASE, f3, rd, 5'($urandom), rs2);
      3, 4, 5: return enc_i(rvcore_pkg::OPC_I, f3, rd, 5'($urandom),
                            (f3 == rvcore_pkg::F3_SLL || f3 == rvcore_pkg::F3_SRL) &&
                            $urandom_range(5) != 0 ? {6'd0, imm[5:0]} : imm);
      6, 7:    return enc_i(rvcore_pkg::OPC_LD,
                            ($urandom_range(7) == 0) ? f3 : rvcore_pkg::F3_DW,
                            rd, rs1, imm);
      8, 9:    return ($urandom_range(7) == 0) ? {25'($urandom), rvcore_pkg::OPC_SD} :
                      enc_s(rs1, rs2, imm);
      10, 11:  return enc_b(f3, 5'($urandom), 5'($urandom), 13'($urandom));
      12:      return {25'($urandom), rvcore_pkg::OPC_JAL};
      13:      return enc_i(rvcore_pkg::OPC_JALR,
                            ($urandom_range(5) == 0) ? f3 : rvcore_pkg::F3_ADD, rd,
                            5'($urandom), imm);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    send_instr(enc_i(rvcore_pkg::OPC_I, rvcore_pkg::F3_ADD, 5'd1, 5'd0, 12'h7FF));
    send_instr(enc_i(rvcore_pkg::OPC_I, rvcore_pkg::F3_ADD, 5'd2, 5'd0, 12'h800));
    send_instr(enc_i(rvcore_pkg::OPC_I, rvcore_pkg::F3_SLL, 5'd3, 5'd2, 12'd63));
    send_instr(enc_i(rvcore_pkg::OPC_I, rvcore_pkg::F3_SRL, 5'd4, 5'd2, 12'd1));
    send_instr(enc_i(rvcore_pkg::OPC_I, rvcore_pkg::F3_SLL, 5'd4, 5'd2, 12'h401));
    send_instr(enc_r(rvcore_pkg::F7_SUB, rvcore_pkg::F3_ADD, 5'd5, 5'd0, 5'd3));
    for (int f = 0; f < 8; f++)
      send_instr(enc_r(rvcore_pkg::F7_BASE, f[2:0], 5'd6, 5'd2, 5'd1));
    send_instr(enc_r(7'h01, rvcore_pkg::F3_ADD, 5'd7, 5'd1, 5'd2));
    send_instr(enc_s(5'd2, 5'd2, 12'hFFF));
    send_instr(enc_i(rvcore_pkg::OPC_LD, rvcore_pkg::F3_DW, 5'd8, 5'd2, 12'hFFF));
    send_instr(enc_i(rvcore_pkg::OPC_LD, rvcore_pkg::F3_DW, 5'd0, 5'd0, 12'h3FC));
    send_instr(enc_b(rvcore_pkg::F3_BGE, 5'd1, 5'd2, 13'h0008));
    send_instr(enc_b(rvcore_pkg::F3_BLT, 5'd2, 5'd1, 13'h1FF8));
    send_instr(enc_b(rvcore_pkg::F3_BEQ, 5'd0, 5'd0, 13'h0FFE));
    send_instr(enc_b(rvcore_pkg::F3_BNE, 5'd0, 5'd0, 13'h0010));
    send_instr({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd9, rvcore_pkg::OPC_JAL});
    send_instr(enc_i(rvcore_pkg::OPC_JALR, rvcore_pkg::F3_ADD, 5'd10, 5'd1, 12'h001));
    send_instr(32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_instr(random_instr());
    drain();
  endtask

  task automatic test_backpressure;
    -> hold_go;
    for (int i = 0; i < 40; i++) send_instr(random_instr());
    drain();
  endtask

  initial begin
    model_pc = '0; model_last = '0;
    foreach (model_regs[i]) model_regs[i] = '0;
    foreach (model_mem[i]) model_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_last_addr(32'd0);
    test_directed();
    send_idle_pct = 24; recv_idle_pct = 61;
    write_last_addr(32'hFFFF_FFFF);
    test_random(450);
    send_idle_pct = 61; recv_idle_pct = 24;
    write_last_addr($urandom);
    test_random(450);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_last_addr(32'h0000_0400);
    test_random(410);
    test_backpressure();
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("Verification failed");
    $finish;
  end

endmodule
